[hw/rtl/string_key_bucket_hash_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef STRING_KEY_BUCKET_HASH_CORE_DEFINES_SVH
`define STRING_KEY_BUCKET_HASH_CORE_DEFINES_SVH

// Clocked property with reset disable.
`define SKBH_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

// Held condition implies a stable signal on the next edge.
`define SKBH_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("%m: signal changed while held");

`endif

[hw/rtl/skbh_pkg.sv]
package skbh_pkg;

	// Hash arithmetic constants
	localparam int HASH_W = 30;
	localparam int ACC_W = 38;
	localparam int RED_STEPS = 8;
	localparam int STEP_W = 3;
	localparam logic [ACC_W-1:0] HASH_MOD_ACC = 38'd1000000009;
	localparam logic [ACC_W-1:0] HASH_BASE_ACC = 38'd53;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;

	// One finished key hash moving into or out of the queue
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} hash_req_t;

endpackage

[hw/rtl/skbh_front.sv]
module skbh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] key_byte
	input  logic                s_tlast,   // key_last
	output skbh_pkg::hash_req_t push_req,
	input  logic                push_ready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                       state_q;
	logic [skbh_pkg::HASH_W-1:0]      hash_q;
	logic [skbh_pkg::HASH_W-1:0]      power_q;
	logic [skbh_pkg::ACC_W-1:0]       acc_q;
	logic [skbh_pkg::ACC_W-1:0]       pw_q;
	logic [skbh_pkg::STEP_W-1:0]      step_q;
	logic                             last_q;

	logic [skbh_pkg::ACC_W-1:0]       mod_shift;
	logic [skbh_pkg::ACC_W-1:0]       acc_nxt;
	logic [skbh_pkg::ACC_W-1:0]       pw_nxt;
	logic [skbh_pkg::ACC_W-1:0]       acc_init;
	logic [skbh_pkg::ACC_W-1:0]       pw_init;

	assign s_tready = (state_q == ST_IDLE);
	assign push_req.valid = (state_q == ST_PUSH);
	assign push_req.hash = hash_q;

	// hash + byte * power, and power * 53, before reduction
	assign acc_init = skbh_pkg::ACC_W'(hash_q)
		+ skbh_pkg::ACC_W'(s_tdata) * skbh_pkg::ACC_W'(power_q);
	assign pw_init = skbh_pkg::ACC_W'(power_q) * skbh_pkg::HASH_BASE_ACC;

	// one restoring step: subtract mod << step when it fits
	assign mod_shift = skbh_pkg::HASH_MOD_ACC << step_q;
	assign acc_nxt = (acc_q >= mod_shift) ? acc_q - mod_shift : acc_q;
	assign pw_nxt = (pw_q >= mod_shift) ? pw_q - mod_shift : pw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q <= '0;
			power_q <= skbh_pkg::HASH_W'(1);
			acc_q <= '0;
			pw_q <= '0;
			step_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						acc_q <= acc_init;
						pw_q <= pw_init;
						last_q <= s_tlast;
						step_q <= skbh_pkg::STEP_W'(skbh_pkg::RED_STEPS - 1);
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					acc_q <= acc_nxt;
					pw_q <= pw_nxt;
					if (step_q == '0) begin
						hash_q <= acc_nxt[skbh_pkg::HASH_W-1:0];
						power_q <= pw_nxt[skbh_pkg::HASH_W-1:0];
						state_q <= last_q ? ST_PUSH : ST_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_PUSH: begin
					// key done: hand off and restart the running state
					if (push_ready) begin
						hash_q <= '0;
						power_q <= skbh_pkg::HASH_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/skbh_queue.sv]
module skbh_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  skbh_pkg::hash_req_t push_req,
	output logic                push_ready,
	output skbh_pkg::hash_req_t pop_req,
	input  logic                pop
);

	localparam int CNT_W = skbh_pkg::QPTR_W + 1;

	logic [skbh_pkg::HASH_W-1:0] entries_q [skbh_pkg::QUEUE_DEPTH];
	logic [skbh_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [skbh_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (count_q != CNT_W'(skbh_pkg::QUEUE_DEPTH));
	assign do_push = push_req.valid && push_ready;
	assign do_pop = pop && (count_q != '0);
	assign pop_req.valid = (count_q != '0);
	assign pop_req.hash = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_req.hash;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/skbh_back.sv]
module skbh_back #(
	parameter int BUCKET_WIDTH = 16,
	localparam int TDATA_W = ((skbh_pkg::HASH_W + BUCKET_WIDTH + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  skbh_pkg::hash_req_t     pop_req,
	output logic                    pop,
	input  logic [BUCKET_WIDTH-1:0] bucket_count,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [TDATA_W-1:0]      m_tdata
);

	localparam int CNT_W = $clog2(skbh_pkg::HASH_W);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [skbh_pkg::HASH_W-1:0] dvd_q;
	logic [skbh_pkg::HASH_W-1:0] hv_q;
	logic [BUCKET_WIDTH-1:0]     div_q;
	logic [BUCKET_WIDTH-1:0]     rem_q;
	logic                        m_tvalid_q;
	logic [TDATA_W-1:0]          m_tdata_q;

	logic [BUCKET_WIDTH:0]       trial;
	logic [BUCKET_WIDTH:0]       diff;
	logic [BUCKET_WIDTH-1:0]     rem_nxt;
	logic [BUCKET_WIDTH-1:0]     bucket;
	logic                        out_free;
	logic                        finish;

	assign pop = !busy_q && pop_req.valid;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish = busy_q && (cnt_q == '0) && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// restoring remainder step, one hash bit per cycle; the last bit waits for a free output
	assign trial = {rem_q, dvd_q[skbh_pkg::HASH_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[BUCKET_WIDTH-1:0]
		: trial[BUCKET_WIDTH-1:0];
	// zero bucket count gives index 0
	assign bucket = (div_q == '0) ? '0 : rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(skbh_pkg::HASH_W - 1);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= pop_req.hash;
			hv_q <= pop_req.hash;
			div_q <= bucket_count;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			dvd_q <= {dvd_q[skbh_pkg::HASH_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= TDATA_W'({bucket, hv_q});
		end
	end

endmodule

[hw/rtl/string_key_bucket_hash_core.sv]
// Rolling polynomial hash of a byte-serial key (base 53, modulo 1000000009) with a
// bucket index equal to the hash modulo bucket_count (0 when bucket_count is 0).
// Send key bytes on s_*, with s_tlast on the final byte; each key yields one
// result on m_*. Each key byte occupies the front end until it is reduced: the
// accepting step forms hash + byte * power and power * 53, then eight restoring
// subtract steps reduce both modulo 1000000009. The last byte of a key then
// waits in a push state to enter a two-entry queue. The back end pops a hash and
// computes the bucket index with a bit-serial remainder, finishing one key before
// it pops the next, while the front keeps hashing the next key. bucket_count is
// sampled when the back end starts a key, so write it only while no key is in
// flight. No clearing pass is needed after reset.
module string_key_bucket_hash_core #(
	parameter int BUCKET_WIDTH = 16,
	localparam int TDATA_W = ((skbh_pkg::HASH_W + BUCKET_WIDTH + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [7:0] key_byte
	input  logic                    s_tlast,   // key_last
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // [29:0] hash_value, then bucket_index
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [BUCKET_WIDTH-1:0] cfg_data   // bucket_count
);

	logic [BUCKET_WIDTH-1:0] bucket_count_q;
	skbh_pkg::hash_req_t     push_req;
	skbh_pkg::hash_req_t     pop_req;
	logic                    push_ready;
	logic                    pop;

	assign cfg_ready = 1'b1;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_WIDTH'(64);
		end else if (cfg_valid) begin
			bucket_count_q <= cfg_data;
		end
	end

	skbh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_req   (push_req),
		.push_ready (push_ready)
	);

	skbh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_req   (push_req),
		.push_ready (push_ready),
		.pop_req    (pop_req),
		.pop        (pop)
	);

	skbh_back #(
		.BUCKET_WIDTH (BUCKET_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_req      (pop_req),
		.pop          (pop),
		.bucket_count (bucket_count_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule

[hw/rtl/skbh_checker.sv]
`include "string_key_bucket_hash_core_defines.svh"

module skbh_checker #(
	parameter int BUCKET_WIDTH = 16,
	localparam int TDATA_W = ((skbh_pkg::HASH_W + BUCKET_WIDTH + 7) / 8) * 8
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tvalid,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [TDATA_W-1:0]      m_tdata
);

	// stalled result stays offered
	`SKBH_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)

	// stalled result keeps its data
	`SKBH_ASSERT_HOLD(a_out_stable, clk, arst_n, m_tvalid && !m_tready, m_tdata)

	// hash is always reduced below the modulus
	`SKBH_ASSERT(a_hash_range, clk, arst_n, m_tvalid |-> (m_tdata[29:0] < 30'd1000000009))

	// a key byte keeps the front busy for the reduction that follows
	`SKBH_ASSERT(a_front_busy, clk, arst_n, s_tvalid && s_tready |=> !s_tready)

endmodule

bind string_key_bucket_hash_core skbh_checker #(
	.BUCKET_WIDTH (BUCKET_WIDTH)
) u_skbh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);

[bench/string_key_bucket_hash_core_tb.sv]
`timescale 1ns / 1ps

module string_key_bucket_hash_core_tb;

	localparam int BUCKET_W = 16;
	localparam int HASH_W = skbh_pkg::HASH_W;
	localparam int TDATA_W = ((HASH_W + BUCKET_W + 7) / 8) * 8;
	localparam bit [63:0] HASH_MODULUS = 64'd1000000009;
	localparam bit [63:0] HASH_RADIX = 64'd53;
	localparam int SETTLE_CYCLES = 48;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_PHASES = 10;
	localparam int RANDOM_BYTES = 1450;

	typedef logic [7:0] key_bytes_t[$];

	// One finished key as the block should report it
	typedef struct {
		logic [HASH_W-1:0]   hash;
		logic [BUCKET_W-1:0] bucket;
	} key_digest_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [7:0] key_byte
	logic                s_tlast;   // key_last
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;   // [29:0] hash_value, [45:30] bucket_index
	logic                cfg_valid;
	logic                cfg_ready;
	logic [BUCKET_W-1:0] cfg_data;  // bucket_count

	// Predictor state
	bit [63:0]   hash_acc;
	bit [63:0]   power_acc;
	bit [63:0]   bucket_model;
	key_digest_t pending_digests[$];

	// Run bookkeeping
	int          fail_count;
	int          keys_sent;
	int          bytes_sent;
	int          zero_bytes_sent;
	int          digests_checked;
	int          settings_used;
	int          cycle_count;
	int          tx_gap_pct;
	int          rx_stall_pct;
	int          rx_hold;
	logic        rx_ready_next;
	key_bytes_t  key_buf;

	string_key_bucket_hash_core #(
		.BUCKET_WIDTH(BUCKET_W)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Idle length: mostly short, now and then long
	function automatic int pick_idle(input int pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 30);
		return $urandom_range(1, 3);
	endfunction

	// Fold one key byte into the running hash; a final byte yields a digest
	task automatic absorb_key_byte(input logic [7:0] kbyte, input logic klast);
		key_digest_t d;
		hash_acc = (hash_acc + 64'(kbyte) * power_acc) % HASH_MODULUS;
		power_acc = (power_acc * HASH_RADIX) % HASH_MODULUS;
		if (klast) begin
			d.hash = hash_acc[HASH_W-1:0];
			d.bucket = (bucket_model == 0) ? '0 : BUCKET_W'(hash_acc % bucket_model);
			pending_digests.push_back(d);
			hash_acc = 0;
			power_acc = 1;
			keys_sent++;
		end
	endtask

	// Stream one key, one request per byte, with random gaps
	task automatic send_key(input key_bytes_t key);
		int gap;
		for (int i = 0; i < key.size(); i++) begin
			gap = pick_idle(tx_gap_pct);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= key[i];
			s_tlast <= (i == key.size() - 1);
			do @(posedge clk); while (!s_tready);
			absorb_key_byte(key[i], i == key.size() - 1);
			bytes_sent++;
			if (key[i] == 8'h00)
				zero_bytes_sent++;
		end
	endtask

	// Drop the request line and let the block drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bucket_count(input logic [BUCKET_W-1:0] count);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		bucket_model = count;
		settings_used++;
	endtask

	// Random key: mostly short, some long enough to wrap the modulus many times
	task automatic build_random_key(output key_bytes_t key);
		int len;
		int pick;
		key = {};
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				key.push_back(8'h00);
			else if (pick == 1)
				key.push_back(8'hff);
			else
				key.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	// Result check and output back-pressure
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digests.size() == 0) begin
				$error("unexpected result: hash_value=%0d bucket_index=%0d",
					m_tdata[HASH_W-1:0], m_tdata[HASH_W +: BUCKET_W]);
				fail_count++;
			end else begin
				if (m_tdata[HASH_W-1:0] != pending_digests[0].hash) begin
					$error("hash_value: expected %0d, got %0d",
						pending_digests[0].hash, m_tdata[HASH_W-1:0]);
					fail_count++;
				end
				if (m_tdata[HASH_W +: BUCKET_W] != pending_digests[0].bucket) begin
					$error("bucket_index: expected %0d, got %0d",
						pending_digests[0].bucket, m_tdata[HASH_W +: BUCKET_W]);
					fail_count++;
				end
				void'(pending_digests.pop_front());
				digests_checked++;
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			rx_ready_next = 1'b0;
		end else begin
			rx_hold = pick_idle(rx_stall_pct);
			rx_ready_next = (rx_hold == 0);
			if (rx_hold > 0)
				rx_hold--;
		end
		m_tready <= rx_ready_next;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Field extremes, zero bytes and a long key, at the reset bucket count
	task automatic test_directed_keys();
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		key_buf = {8'h01};
		send_key(key_buf);
		key_buf = {8'hff};
		send_key(key_buf);
		key_buf = {8'h00};
		send_key(key_buf);
		key_buf = {8'h80};
		send_key(key_buf);
		key_buf = {8'h7f, 8'h01};
		send_key(key_buf);
		key_buf = {8'haa, 8'h00, 8'h55};
		send_key(key_buf);
		key_buf = {};
		for (int i = 0; i < 10; i++)
			key_buf.push_back(8'hff);
		send_key(key_buf);
		wait_idle();
	endtask

	// Smallest, largest and zero bucket counts
	task automatic test_bucket_extremes();
		set_bucket_count(16'd1);
		key_buf = {8'hff, 8'hff};
		send_key(key_buf);
		set_bucket_count(16'hffff);
		key_buf = {8'h5a, 8'hc3, 8'h11};
		send_key(key_buf);
		set_bucket_count(16'd0);
		key_buf = {8'h42};
		send_key(key_buf);
		wait_idle();
	endtask

	// Random keys over a series of bucket counts and idling mixes
	task automatic test_random_keys();
		int phase_start;
		logic [BUCKET_W-1:0] count;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: count = 16'd0;
				1: count = 16'd1;
				2: count = 16'hffff;
				3: count = 16'd64;
				default: begin
					case ($urandom_range(0, 2))
						0: count = 16'($urandom_range(2, 300));
						1: count = 16'(1 << $urandom_range(1, 15));
						default: count = 16'($urandom_range(1, 65535));
					endcase
				end
			endcase
			set_bucket_count(count);
			if (phase % 3 == 0) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct = $urandom_range(10, 50);
				rx_stall_pct = $urandom_range(10, 50);
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_BYTES / RANDOM_PHASES) begin
				build_random_key(key_buf);
				send_key(key_buf);
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		fail_count = 0;
		keys_sent = 0;
		bytes_sent = 0;
		zero_bytes_sent = 0;
		digests_checked = 0;
		settings_used = 1;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 0;
		hash_acc = 0;
		power_acc = 1;
		bucket_model = 64;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_keys();
		test_bucket_extremes();
		test_random_keys();

		$display("Hashed %0d keys from %0d bytes (%0d of them zero), %0d results checked",
			keys_sent, bytes_sent, zero_bytes_sent, digests_checked);
		$display("Bucket counts used: %0d settings, zero, one and full range among them",
			settings_used);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[string_key_bucket_hash_core.f]
+incdir+hw/rtl
hw/rtl/skbh_pkg.sv
hw/rtl/skbh_front.sv
hw/rtl/skbh_queue.sv
hw/rtl/skbh_back.sv
hw/rtl/string_key_bucket_hash_core.sv
hw/rtl/skbh_checker.sv
bench/string_key_bucket_hash_core_tb.sv
